// ===== sv/dfs_cycle_enumerator_macros.svh =====
// Assertion macros of the cycle enumerator top level.
// No dependencies.
`ifndef DFS_CYCLE_ENUMERATOR_MACROS_SVH
`define DFS_CYCLE_ENUMERATOR_MACROS_SVH
// implication checked on every edge outside reset
`define DCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the following cycle
`define DCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== sv/dce_pkg.sv =====
// Shared types and constants of the DFS cycle enumerator.
// No dependencies.
package dce_pkg;
	localparam int unsigned VW = 3;
	localparam int unsigned PATH_W = 27;
	localparam int unsigned CNT_W = 6;
	localparam int unsigned LEN_W = 4;
	localparam int unsigned MAX_CYCLES = 36;
	localparam int unsigned OUT_W = 40;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN = 1'b1;
	localparam logic [1:0] COL_WHITE = 2'd0;
	localparam logic [1:0] COL_GREY = 2'd1;
	localparam logic [1:0] COL_BLACK = 2'd2;

	typedef struct packed {
		logic [PATH_W-1:0] path_vertices;
		logic [LEN_W-1:0] path_length;
		logic [CNT_W-1:0] cycle_number;
		logic is_summary;
	} res_t;
endpackage

// ===== sv/dfs_cycle_enumerator.sv =====
// Top level of the DFS cycle enumerator: matrix, color, parent and stack memories, sequencer.
// Depends on dce_pkg, dce_out_reg and dfs_cycle_enumerator_macros.svh.
//
// Input stream s_axis: tdata = {row_edges[11:4], row_index[3:1], opcode[0]}.
// A load item (opcode 0) writes one adjacency row and gives no result.
// A run item (opcode 1) searches the graph depth first and sends one item
// per cycle found, up to MAX_CYCLES of them, then a summary item with tlast high.
// Output stream m_axis: tdata = {2'b00, path_vertices, path_length,
// cycle_number, is_summary} with is_summary at bit 0; tlast marks the summary.
// A run clears colors and parents, then checks each root in turn, probes the
// stack top, reads a neighbor's color when the probe finds one, and walks the
// parent chain of each cycle found along its tree edges; each item is
// registered in the output register before it leaves.
// One item at a time: s_axis_tready is low while a run is busy.
// Reset empties the output register and the sequencer; the matrix is
// undefined until loaded. A stalled receiver holds the sequencer.
module dfs_cycle_enumerator import dce_pkg::*; #(
	parameter int unsigned NUM_VERTICES = 8
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [15:0] s_axis_tdata, // opcode, row_index, row_edges, ignored pad
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata, // is_summary, cycle_number, path_length, path_vertices
	output logic m_axis_tlast
);
`include "dfs_cycle_enumerator_macros.svh"
	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_ROOT, S_RCHK, S_TOP, S_ROW, S_SCAN, S_UCOL,
		S_WALK, S_WPAR, S_EMIT, S_SUM
	} state_t;

	state_t state_q;
	logic [7:0] adj_mem [8];
	logic [1:0] col_mem [8];
	logic [VW-1:0] par_mem [8];
	logic [6:0] stk_mem [8];
	logic [3:0] sp_q;
	logic [3:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0] row_s1;
	logic [1:0] col_s1;
	logic [VW-1:0] par_s1;
	logic [6:0] stk_s1;
	logic [VW-1:0] v_q, u_q, cur_q;
	logic [3:0] next_q;
	logic [3:0] n_q;
	logic [PATH_W-VW-1:0] acc_q;
	logic [PATH_W-1:0] path_q;
	logic [3:0] len_q;
	logic [2:0] clr_q;
	logic ov_valid, ov_ready, ov_last;
	res_t ov_res;
	logic [3:0] first_u;
	logic [7:0] vmask;
	logic [VW-1:0] in_row;
	logic [VW-1:0] col_ra;
	logic [4:0] top_sh;

	assign vmask = 8'((9'd1 << NUM_VERTICES) - 9'd1);
	assign in_row = s_axis_tdata[3:1];
	assign s_axis_tready = (state_q == S_IDLE);
	assign col_ra = (state_q == S_SCAN) ? 3'(first_u) : 3'(root_q);
	assign top_sh = {1'b0, n_q} * 5'd3 + 5'd3;

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready && s_axis_tdata[0] == OP_LOAD
				&& 4'(in_row) < 4'(NUM_VERTICES)) begin
			adj_mem[in_row] <= s_axis_tdata[11:4] & vmask;
		end
		row_s1 <= adj_mem[stk_s1[VW-1:0]];
	end

	always_comb begin
		first_u = 4'(NUM_VERTICES);
		for (int i = 7; i >= 0; i--) begin
			if (4'(i) >= next_q && 4'(i) < 4'(NUM_VERTICES) && row_s1[i]) begin
				first_u = 4'(i);
			end
		end
	end

	always_comb begin
		ov_res = '0;
		ov_last = 1'b0;
		ov_valid = 1'b0;
		if (state_q == S_EMIT) begin
			ov_valid = 1'b1;
			ov_res.cycle_number = cnt_q;
			ov_res.path_length = len_q;
			ov_res.path_vertices = path_q;
		end else if (state_q == S_SUM) begin
			ov_valid = 1'b1;
			ov_last = 1'b1;
			ov_res.is_summary = 1'b1;
			ov_res.cycle_number = cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_mem[col_ra];
		par_s1 <= par_mem[cur_q];
		stk_s1 <= stk_mem[3'(sp_q - 4'd1)];
		unique case (state_q)
			S_CLEAR: begin
				col_mem[clr_q] <= COL_WHITE;
				par_mem[clr_q] <= '0;
			end
			S_RCHK: begin
				if (col_s1 == COL_WHITE) begin
					col_mem[3'(root_q)] <= COL_GREY;
					stk_mem[0] <= {4'd0, 3'(root_q)};
				end
			end
			S_SCAN: begin
				if (first_u >= 4'(NUM_VERTICES)) begin
					col_mem[v_q] <= COL_BLACK;
				end else begin
					stk_mem[3'(sp_q - 4'd1)] <= {first_u + 4'd1, v_q};
				end
			end
			S_UCOL: begin
				if (col_s1 == COL_WHITE) begin
					par_mem[u_q] <= v_q;
					col_mem[u_q] <= COL_GREY;
					stk_mem[3'(sp_q)] <= {4'd0, u_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sp_q <= '0;
			root_q <= '0;
			cnt_q <= '0;
			clr_q <= '0;
			v_q <= '0;
			u_q <= '0;
			cur_q <= '0;
			next_q <= '0;
			n_q <= '0;
			acc_q <= '0;
			path_q <= '0;
			len_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tdata[0] == OP_RUN) begin
						state_q <= S_CLEAR;
						clr_q <= '0;
						cnt_q <= '0;
						sp_q <= '0;
						root_q <= '0;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 3'd1;
					if (clr_q == 3'd7) state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_q >= 4'(NUM_VERTICES)) begin
						state_q <= S_SUM;
					end else begin
						state_q <= S_RCHK;
					end
				end
				S_RCHK: begin
					root_q <= root_q + 4'd1;
					if (col_s1 == COL_WHITE) begin
						sp_q <= 4'd1;
						state_q <= S_TOP;
					end else begin
						state_q <= S_ROOT;
					end
				end
				S_TOP: begin
					state_q <= S_ROW;
				end
				S_ROW: begin
					v_q <= stk_s1[VW-1:0];
					next_q <= stk_s1[6:VW];
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (first_u >= 4'(NUM_VERTICES)) begin
						sp_q <= sp_q - 4'd1;
						state_q <= (sp_q == 4'd1) ? S_ROOT : S_TOP;
					end else begin
						u_q <= 3'(first_u);
						state_q <= S_UCOL;
					end
				end
				S_UCOL: begin
					if (col_s1 == COL_GREY && cnt_q < 6'(MAX_CYCLES)) begin
						cur_q <= v_q;
						n_q <= '0;
						acc_q <= '0;
						state_q <= S_WALK;
					end else begin
						if (col_s1 == COL_WHITE) sp_q <= sp_q + 4'd1;
						state_q <= S_TOP;
					end
				end
				S_WALK: begin
					if (cur_q == u_q || n_q == 4'd8) begin
						cnt_q <= cnt_q + 6'd1;
						path_q <= {acc_q, u_q} | (PATH_W'(u_q) << top_sh);
						len_q <= n_q + 4'd2;
						state_q <= S_EMIT;
					end else begin
						acc_q <= {acc_q[PATH_W-2*VW-1:0], cur_q};
						n_q <= n_q + 4'd1;
						state_q <= S_WPAR;
					end
				end
				S_WPAR: begin
					cur_q <= par_s1;
					state_q <= S_WALK;
				end
				S_EMIT: begin
					if (ov_ready) state_q <= S_TOP;
				end
				S_SUM: begin
					if (ov_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	dce_out_reg u_out (
		.clk(clk), .arst_n(arst_n),
		.in_valid(ov_valid),
		.in_ready(ov_ready), .in_res(ov_res), .in_last(ov_last),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	logic unused_ok;
	assign unused_ok = ^s_axis_tdata[15:12];

	`DCE_ASSERT_IMP(a_sp_bound, clk, arst_n, 1'b1, sp_q <= 4'(NUM_VERTICES))
	`DCE_ASSERT_IMP(a_busy_ready, clk, arst_n, state_q != S_IDLE, !s_axis_tready)
	`DCE_ASSERT_IMP(a_emit_len, clk, arst_n, state_q == S_EMIT, len_q >= 4'd2 && len_q <= 4'd9)
	`DCE_ASSERT_NEXT(a_sum_idle, clk, arst_n, state_q == S_SUM && ov_ready, state_q == S_IDLE)
endmodule

// ===== sv/dce_out_reg.sv =====
// Output pipeline register of the cycle enumerator.
// Depends on dce_pkg.
module dce_out_reg import dce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input res_t in_res,
	input logic in_last,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,
	output logic m_axis_tlast
);
	res_t res_q;
	logic valid_q, last_q;

	assign in_ready = !valid_q || m_axis_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
			last_q <= in_last;
		end
	end
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {2'b00, res_q.path_vertices, res_q.path_length,
		res_q.cycle_number, res_q.is_summary};
	assign m_axis_tlast = last_q;
endmodule
